@@ hw/rtl/ntcfe_pkg.sv @@
// ============================================================================
// ntcfe_pkg
// Shared types and constants for the NMEA time/coordinate field extractor.
// ============================================================================
`default_nettype none

package ntcfe_pkg;

    localparam int unsigned COORD_MAX_CHARS = 14;
    localparam int unsigned TIME_LEN        = 8;
    localparam int unsigned BUF_DEPTH       = 4;
    localparam int unsigned BUF_AW          = $clog2(BUF_DEPTH);

    localparam logic [7:0] CHR_COMMA = 8'h2C;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    localparam logic [1:0] FID_TIME = 2'd0;
    localparam logic [1:0] FID_C1   = 2'd1;
    localparam logic [1:0] FID_C2   = 2'd2;
    localparam logic [1:0] FID_END  = 2'd3;

    typedef struct packed {
        logic [1:0] field_id;
        logic [3:0] char_pos;
        logic [7:0] char_value;
        logic       last;
    } t_result;

    // Up to two results per accepted byte; num counts valid entries.
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_res_pair;

endpackage

`default_nettype wire

@@ hw/rtl/ntcfe_decode.sv @@
// ============================================================================
// ntcfe_decode
// Per-byte sentence state and result generation (zero to two results).
// ============================================================================
`default_nettype none

module ntcfe_decode (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_rx_byte,
    output      ntcfe_pkg::t_res_pair o_push
);

    typedef enum logic [1:0] {
        MODE_SCAN = 2'd0,
        MODE_TIME = 2'd1,
        MODE_C1   = 2'd2,
        MODE_C2   = 2'd3
    } t_mode;

    t_mode      r_mode,  n_mode;
    logic [2:0] r_comma, n_comma;
    logic [3:0] r_pos,   n_pos;
    ntcfe_pkg::t_res_pair w_pair;
    logic [4:0] w_pos_inc;
    logic [3:0] w_tpos;

    assign w_pos_inc = {1'b0, r_pos} + 5'd1;

    always_comb begin
        n_mode    = r_mode;
        n_comma   = r_comma;
        n_pos     = r_pos;
        w_tpos    = r_pos;
        w_pair    = '0;
        if (i_rx_byte == ntcfe_pkg::CHR_NUL) begin
            w_pair.num = 2'd1;
            w_pair.r0  = '{ntcfe_pkg::FID_END, 4'd0, 8'd0, 1'b1};
            n_mode     = MODE_SCAN;
            n_comma    = 3'd0;
            n_pos      = 4'd0;
        end else begin
            unique case (r_mode)
                MODE_TIME: begin
                    if (r_pos == 4'd1 || r_pos == 4'd4) begin
                        w_pair.num = 2'd2;
                        w_pair.r0  = '{ntcfe_pkg::FID_TIME, r_pos, i_rx_byte, 1'b0};
                        w_pair.r1  = '{ntcfe_pkg::FID_TIME, w_pos_inc[3:0],
                                       ntcfe_pkg::CHR_COLON, 1'b1};
                        w_tpos     = r_pos + 4'd2;
                    end else begin
                        w_pair.num = 2'd1;
                        w_pair.r0  = '{ntcfe_pkg::FID_TIME, r_pos, i_rx_byte, 1'b1};
                        w_tpos     = w_pos_inc[3:0];
                    end
                    if ({1'b0, w_tpos} >= 5'(ntcfe_pkg::TIME_LEN)) begin
                        n_mode = MODE_SCAN;
                        n_pos  = 4'd0;
                    end else begin
                        n_pos  = w_tpos;
                    end
                end
                MODE_C1, MODE_C2: begin
                    if (i_rx_byte == ntcfe_pkg::CHR_COMMA) begin
                        n_mode = MODE_SCAN;
                        n_pos  = 4'd0;
                    end else begin
                        w_pair.num = 2'd1;
                        w_pair.r0  = '{(r_mode == MODE_C1) ? ntcfe_pkg::FID_C1
                                                           : ntcfe_pkg::FID_C2,
                                       r_pos, i_rx_byte, 1'b1};
                        if (w_pos_inc >= 5'(ntcfe_pkg::COORD_MAX_CHARS)) begin
                            n_mode = MODE_SCAN;
                            n_pos  = 4'd0;
                        end else begin
                            n_pos  = w_pos_inc[3:0];
                        end
                    end
                end
                MODE_SCAN: begin
                    if (i_rx_byte == ntcfe_pkg::CHR_COMMA) begin
                        if (r_comma != 3'd7) begin
                            n_comma = r_comma + 3'd1;
                        end
                        n_pos = 4'd0;
                        unique case (n_comma)
                            3'd1:    n_mode = MODE_TIME;
                            3'd2:    n_mode = MODE_C1;
                            3'd3:    n_mode = MODE_C2;
                            default: n_mode = MODE_SCAN;
                        endcase
                    end
                end
                default: n_mode = MODE_SCAN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SCAN;
            r_comma <= 3'd0;
            r_pos   <= 4'd0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_comma <= n_comma;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        o_push = w_pair;
        if (!i_accept) begin
            o_push.num = 2'd0;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ntcfe_res_buf.sv @@
// ============================================================================
// ntcfe_res_buf
// Small result queue: pushes up to two results a cycle, pops one.
// ============================================================================
`default_nettype none

module ntcfe_res_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ntcfe_pkg::t_res_pair i_push,
    input  wire logic                 i_pop_ready,
    output      logic                 o_room,
    output      logic                 o_valid,
    output      ntcfe_pkg::t_result   o_head
);

    localparam int unsigned AW = ntcfe_pkg::BUF_AW;

    ntcfe_pkg::t_result r_mem [ntcfe_pkg::BUF_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt, n_cnt;
    logic          w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= (AW+1)'(ntcfe_pkg::BUF_DEPTH - 2));
    assign o_head  = r_mem[r_rd];
    assign w_pop   = o_valid && i_pop_ready;

    always_comb begin
        n_cnt = r_cnt + (AW+1)'(i_push.num) - (AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + AW'(i_push.num);
            r_rd  <= r_rd + AW'(w_pop);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_push.r1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/nmea_time_coordinate_field_extractor.sv @@
// ============================================================================
// nmea_time_coordinate_field_extractor
// Extracts time (as hh:mm:ss) and two coordinate fields from an NMEA byte
// stream, one character result per output transaction.
// ============================================================================
//  channel  dir  handshake                   payload
//  rx       in   i_rx_valid / o_rx_ready     i_rx_byte
//  res      out  o_res_valid / i_res_ready   o_field_id, o_char_pos,
//                                            o_char_value, o_last
//
//  One byte is taken per cycle while o_rx_ready is high; it produces 0, 1
//  or 2 results, which a 4-entry result buffer holds from the next cycle on.
//  o_rx_ready is high while the buffer has room for two results.
//  A byte that yields two results needs two output transactions, so sustained
//  input rate follows the output rate when colons are inserted.
//  Synchronous active-low reset clears the sentence state and the buffer.
`default_nettype none

module nmea_time_coordinate_field_extractor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    output      logic       o_rx_ready,
    input  wire logic [7:0] i_rx_byte,
    output      logic       o_res_valid,
    input  wire logic       i_res_ready,
    output      logic [1:0] o_field_id,
    output      logic [3:0] o_char_pos,
    output      logic [7:0] o_char_value,
    output      logic       o_last
);

    logic                 w_accept;
    ntcfe_pkg::t_res_pair w_push;
    ntcfe_pkg::t_result   w_head;

    assign w_accept = i_rx_valid && o_rx_ready;

    ntcfe_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (w_push)
    );

    ntcfe_res_buf u_res_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop_ready (i_res_ready),
        .o_room      (o_rx_ready),
        .o_valid     (o_res_valid),
        .o_head      (w_head)
    );

    assign o_field_id   = w_head.field_id;
    assign o_char_pos   = w_head.char_pos;
    assign o_char_value = w_head.char_value;
    assign o_last       = w_head.last;

    a_pair_last: assert property (@(posedge i_clk)
        (w_push.num == 2'd2) |-> (!w_push.r0.last && w_push.r1.last))
        else $error("two-result push with wrong last flags");

    a_end_marker: assert property (@(posedge i_clk)
        (w_accept && i_rx_byte == ntcfe_pkg::CHR_NUL) |->
        (w_push.num == 2'd1 && w_push.r0.field_id == ntcfe_pkg::FID_END))
        else $error("sentence end did not push one end marker");

    a_no_push_idle: assert property (@(posedge i_clk)
        !w_accept |-> (w_push.num == 2'd0))
        else $error("result pushed without an input transaction");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_res_valid && o_rx_ready))
        else $error("result buffer not empty after reset");

endmodule

`default_nettype wire
